// ===== sv/gsm_pkg.sv =====
// Shared widths, register indexes and types for the tile gid mapper.
package gsm_pkg;

	localparam int GID_BITS        = 24;
	localparam int CELL_COORD_BITS = 10;

	localparam int TSZ_W   = 9;
	localparam int VIEW_W  = 24;
	localparam int ZOOM_W  = 16;
	localparam int WORD_W  = 64;
	localparam int FIRST_W = 24;
	localparam int COLS_W  = 16;
	localparam int CNT_W   = 24;
	localparam int OUT_W   = 24;
	localparam int IDX_W   = 3;

	localparam int CMP_W   = (GID_BITS > FIRST_W) ? GID_BITS : FIRST_W;
	localparam int WORLD_W = CELL_COORD_BITS + TSZ_W;
	localparam int DIFF_W  = ((WORLD_W + 4 > VIEW_W) ? WORLD_W + 4 : VIEW_W) + 1;
	localparam int PROD_W  = DIFF_W + ZOOM_W;
	localparam int RND_W   = PROD_W + 1 - 12;
	localparam int SRCX_W  = COLS_W + TSZ_W;
	localparam int SRCY_W  = GID_BITS + TSZ_W;

	localparam int LATENCY = GID_BITS + 7;

	localparam logic [IDX_W-1:0] REG_TILE_WIDTH  = 3'd0;
	localparam logic [IDX_W-1:0] REG_TILE_HEIGHT = 3'd1;
	localparam logic [IDX_W-1:0] REG_VIEW_X      = 3'd2;
	localparam logic [IDX_W-1:0] REG_VIEW_Y      = 3'd3;
	localparam logic [IDX_W-1:0] REG_ZOOM        = 3'd4;
	localparam logic [IDX_W-1:0] REG_TILESET_A   = 3'd5;
	localparam logic [IDX_W-1:0] REG_TILESET_B   = 3'd6;

	typedef struct packed {
		logic                    draw;
		logic                    sel;
		logic signed [OUT_W-1:0] dest_x;
		logic signed [OUT_W-1:0] dest_y;
	} div_tag_t;

endpackage

// ===== sv/gsm_dest.sv =====
// Three stage pipeline turning a world pixel position into a rounded screen position.
module gsm_dest
	import gsm_pkg::*;
(
	input  logic                      clk,
	input  logic [WORLD_W-1:0]        world,
	input  logic signed [VIEW_W-1:0]  view,
	input  logic [ZOOM_W-1:0]         zoom,
	output logic signed [OUT_W-1:0]   dest
);

	logic signed [DIFF_W-1:0] diff;
	logic                     neg_s1, neg_s2;
	logic [DIFF_W-1:0]        mag_s1;
	logic [PROD_W-1:0]        prod_s2;
	logic [PROD_W:0]          sum;
	logic [RND_W-1:0]         rnd;

	assign diff = $signed(DIFF_W'(world) << 4) - DIFF_W'(view);
	assign sum  = (PROD_W+1)'(prod_s2) + (PROD_W+1)'(2048);
	assign rnd  = sum[PROD_W:12];

	always_ff @(posedge clk) begin
		neg_s1  <= diff[DIFF_W-1];
		mag_s1  <= diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
		neg_s2  <= neg_s1;
		prod_s2 <= PROD_W'(mag_s1) * PROD_W'(zoom);
		if (neg_s2) begin
			if (rnd > RND_W'(24'd8388607) + RND_W'(1))
				dest <= OUT_W'(24'h800000);
			else
				dest <= OUT_W'(-rnd);
		end else begin
			if (rnd > RND_W'(24'd8388607))
				dest <= OUT_W'(24'h7FFFFF);
			else
				dest <= OUT_W'(rnd);
		end
	end

endmodule

// ===== sv/gsm_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, carrying a tag.
module gsm_div
	import gsm_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [GID_BITS-1:0] dividend,
	input  logic [COLS_W-1:0]   divisor,
	input  div_tag_t            in_tag,
	output logic                out_valid,
	output logic [GID_BITS-1:0] quot,
	output logic [COLS_W-1:0]   rem,
	output div_tag_t            out_tag
);

	logic                vld_s [GID_BITS+1];
	logic [COLS_W-1:0]   rem_s [GID_BITS+1];
	logic [GID_BITS-1:0] dq_s  [GID_BITS+1];
	logic [COLS_W-1:0]   dvs_s [GID_BITS+1];
	div_tag_t            tag_s [GID_BITS+1];

	assign vld_s[0] = in_valid;
	assign rem_s[0] = '0;
	assign dq_s[0]  = dividend;
	assign dvs_s[0] = divisor;
	assign tag_s[0] = in_tag;

	for (genvar i = 0; i < GID_BITS; i++) begin : g_stage
		logic [COLS_W:0] trial;
		logic            take;

		assign trial = {rem_s[i], dq_s[i][GID_BITS-1]};
		assign take  = trial >= {1'b0, dvs_s[i]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[i+1] <= 1'b0;
			else
				vld_s[i+1] <= vld_s[i];
		end

		always_ff @(posedge clk) begin
			rem_s[i+1] <= take ? COLS_W'(trial - {1'b0, dvs_s[i]}) : COLS_W'(trial);
			dq_s[i+1]  <= {dq_s[i][GID_BITS-2:0], take};
			dvs_s[i+1] <= dvs_s[i];
			tag_s[i+1] <= tag_s[i];
		end
	end

	assign out_valid = vld_s[GID_BITS];
	assign quot      = dq_s[GID_BITS];
	assign rem       = rem_s[GID_BITS];
	assign out_tag   = tag_s[GID_BITS];

endmodule

// ===== sv/tile_gid_source_dest_mapper_top.sv =====
// Top level of the tile gid mapper: tileset selection, destination path, divider and output stages.
//
// A map cell (gid, row, col) is taken at each rising edge where start is high
// and busy is low; busy stays low, so one cell can be taken every cycle.
// Once a cell has passed through the pipeline, done is high for one
// cycle with draw, tileset_sel, the source rectangle corner and the screen
// position of that cell; results leave in the order the cells came in.
// The pipeline runs through the selection, the three stage destination
// path, the divider, which resolves one quotient bit per stage, and the
// final multiply and saturate stages.
// The receiver cannot stall; every result is shown once and must be taken.
// Registers are written through cfg_valid, cfg_index and cfg_data; cfg_ready
// is always high. Writes are meant only while no cell is in flight.
// Reset clears the pipeline and loads tile size 16 by 16, a view of zero,
// a zoom of one and both tilesets disabled.
// A skipped cell gives draw low and every other field zero.
module tile_gid_source_dest_mapper_top
	import gsm_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [GID_BITS-1:0]        gid,
	input  logic [CELL_COORD_BITS-1:0] row,
	input  logic [CELL_COORD_BITS-1:0] col,
	output logic                       done,
	output logic                       draw,
	output logic                       tileset_sel,
	output logic [OUT_W-1:0]           src_x,
	output logic [OUT_W-1:0]           src_y,
	output logic signed [OUT_W-1:0]    dest_x,
	output logic signed [OUT_W-1:0]    dest_y,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [IDX_W-1:0]           cfg_index,
	input  logic [WORD_W-1:0]          cfg_data
);

	logic [TSZ_W-1:0]         tile_width_q, tile_height_q;
	logic signed [VIEW_W-1:0] view_x_q, view_y_q;
	logic [ZOOM_W-1:0]        zoom_q;
	logic [WORD_W-1:0]        ts_a_q, ts_b_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tile_width_q  <= TSZ_W'(16);
			tile_height_q <= TSZ_W'(16);
			view_x_q      <= '0;
			view_y_q      <= '0;
			zoom_q        <= ZOOM_W'(256);
			ts_a_q        <= '0;
			ts_b_q        <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_TILE_WIDTH:  tile_width_q  <= cfg_data[TSZ_W-1:0];
				REG_TILE_HEIGHT: tile_height_q <= cfg_data[TSZ_W-1:0];
				REG_VIEW_X:      view_x_q      <= cfg_data[VIEW_W-1:0];
				REG_VIEW_Y:      view_y_q      <= cfg_data[VIEW_W-1:0];
				REG_ZOOM:        zoom_q        <= cfg_data[ZOOM_W-1:0];
				REG_TILESET_A:   ts_a_q        <= cfg_data;
				REG_TILESET_B:   ts_b_q        <= cfg_data;
				default: ;
			endcase
		end
	end

	// Stage 1: the cell word as taken.
	logic                       vld_s1;
	logic [GID_BITS-1:0]        gid_s1;
	logic [CELL_COORD_BITS-1:0] row_s1, col_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else
			vld_s1 <= start && !busy;
	end

	always_ff @(posedge clk) begin
		gid_s1 <= gid;
		row_s1 <= row;
		col_s1 <= col;
	end

	// Tileset selection on stage 1.
	logic [CMP_W-1:0]   gid_c, first_a, first_b, first_c, local_c;
	logic [CNT_W-1:0]   cnt_c;
	logic [COLS_W-1:0]  cols_c;
	logic               en_a, en_b, sel_c, hit_c, draw_c;

	assign gid_c   = CMP_W'(gid_s1);
	assign first_a = CMP_W'(ts_a_q[FIRST_W-1:0]);
	assign first_b = CMP_W'(ts_b_q[FIRST_W-1:0]);
	assign en_a    = (ts_a_q[WORD_W-1:40] != '0) && (gid_c >= first_a);
	assign en_b    = (ts_b_q[WORD_W-1:40] != '0) && (gid_c >= first_b);
	assign sel_c   = en_b && !(en_a && !(first_b > first_a));
	assign hit_c   = (en_a || en_b) && (gid_s1 != '0);
	assign first_c = sel_c ? first_b : first_a;
	assign cnt_c   = sel_c ? ts_b_q[WORD_W-1:40] : ts_a_q[WORD_W-1:40];
	assign cols_c  = sel_c ? ts_b_q[39:24] : ts_a_q[39:24];
	assign local_c = gid_c - first_c;
	assign draw_c  = hit_c && (local_c < CMP_W'(cnt_c)) && (cols_c != '0);

	// Stage 2 to 5: selection result, travelling beside the destination path.
	logic                vld_s2, vld_s3, vld_s4, vld_s5;
	logic                draw_s2, draw_s3, draw_s4, draw_s5;
	logic                sel_s2, sel_s3, sel_s4, sel_s5;
	logic [GID_BITS-1:0] local_s2, local_s3, local_s4, local_s5;
	logic [COLS_W-1:0]   cols_s2, cols_s3, cols_s4, cols_s5;
	logic [WORLD_W-1:0]  world_x_s2, world_y_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		draw_s2    <= draw_c;
		sel_s2     <= sel_c;
		local_s2   <= local_c[GID_BITS-1:0];
		cols_s2    <= cols_c;
		world_x_s2 <= WORLD_W'(col_s1) * WORLD_W'(tile_width_q);
		world_y_s2 <= WORLD_W'(row_s1) * WORLD_W'(tile_height_q);
		draw_s3    <= draw_s2;
		sel_s3     <= sel_s2;
		local_s3   <= local_s2;
		cols_s3    <= cols_s2;
		draw_s4    <= draw_s3;
		sel_s4     <= sel_s3;
		local_s4   <= local_s3;
		cols_s4    <= cols_s3;
		draw_s5    <= draw_s4;
		sel_s5     <= sel_s4;
		local_s5   <= local_s4;
		cols_s5    <= cols_s4;
	end

	logic signed [OUT_W-1:0] dx_s5, dy_s5;

	gsm_dest u_dest_x (
		.clk   (clk),
		.world (world_x_s2),
		.view  (view_x_q),
		.zoom  (zoom_q),
		.dest  (dx_s5)
	);

	gsm_dest u_dest_y (
		.clk   (clk),
		.world (world_y_s2),
		.view  (view_y_q),
		.zoom  (zoom_q),
		.dest  (dy_s5)
	);

	div_tag_t            tag_in, tag_out;
	logic                div_vld;
	logic [GID_BITS-1:0] quot;
	logic [COLS_W-1:0]   rem;

	assign tag_in = '{draw: draw_s5, sel: sel_s5, dest_x: dx_s5, dest_y: dy_s5};

	gsm_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s5),
		.dividend  (local_s5),
		.divisor   (cols_s5),
		.in_tag    (tag_in),
		.out_valid (div_vld),
		.quot      (quot),
		.rem       (rem),
		.out_tag   (tag_out)
	);

	// Source products, then saturation and the output word.
	logic              vld_m_q;
	div_tag_t          tag_m_q;
	logic [SRCX_W-1:0] px_m_q;
	logic [SRCY_W-1:0] py_m_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_m_q <= 1'b0;
			done    <= 1'b0;
		end else begin
			vld_m_q <= div_vld;
			done    <= vld_m_q;
		end
	end

	always_ff @(posedge clk) begin
		tag_m_q <= tag_out;
		px_m_q  <= SRCX_W'(rem) * SRCX_W'(tile_width_q);
		py_m_q  <= SRCY_W'(quot) * SRCY_W'(tile_height_q);
		if (tag_m_q.draw) begin
			draw        <= 1'b1;
			tileset_sel <= tag_m_q.sel;
			src_x       <= (|(px_m_q >> OUT_W)) ? '1 : OUT_W'(px_m_q);
			src_y       <= (|(py_m_q >> OUT_W)) ? '1 : OUT_W'(py_m_q);
			dest_x      <= tag_m_q.dest_x;
			dest_y      <= tag_m_q.dest_y;
		end else begin
			draw        <= 1'b0;
			tileset_sel <= 1'b0;
			src_x       <= '0;
			src_y       <= '0;
			dest_x      <= '0;
			dest_y      <= '0;
		end
	end

endmodule

// ===== sv/gsm_checker.sv =====
// Port level checks for the tile gid mapper and their binding to the top level.
module gsm_checker
	import gsm_pkg::*;
(
	input logic                    clk,
	input logic                    arst_n,
	input logic                    start,
	input logic                    busy,
	input logic                    done,
	input logic                    draw,
	input logic                    tileset_sel,
	input logic [OUT_W-1:0]        src_x,
	input logic [OUT_W-1:0]        src_y,
	input logic signed [OUT_W-1:0] dest_x,
	input logic signed [OUT_W-1:0] dest_y
);

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("word taken without a result at the fixed latency");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result without a word taken at the fixed latency");

	a_skip_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !draw) |-> (tileset_sel == 1'b0 && src_x == '0 && src_y == '0
			&& dest_x == '0 && dest_y == '0))
		else $error("skipped cell carries non-zero fields");

endmodule

bind tile_gid_source_dest_mapper_top gsm_checker u_gsm_checker (.*);
